>>> sv/fraction_quotient_divider_defines.svh
// Assertion macros for the fraction quotient divider.
`ifndef FRACTION_QUOTIENT_DIVIDER_DEFINES_SVH
`define FRACTION_QUOTIENT_DIVIDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FQD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define FQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fqd_pkg.sv
// Types and constants shared by the fraction quotient divider modules.
package fqd_pkg;

   localparam int DATA_W = 64;
   // One restoring step per stage: first half reduces the numerator, second
   // half produces the fraction bits.
   localparam int STEPS  = 2 * DATA_W;

   typedef struct packed {
      logic [DATA_W-1:0] numerator;
      logic [DATA_W-1:0] denominator;
   } fqd_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] fraction;
      logic              not_a_number;
   } fqd_rsp_type;

   typedef struct packed {
      logic              valid;
      logic              not_a_number;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] dvd;
      logic [DATA_W-1:0] quo;
   } fqd_stage_type;

endpackage

>>> sv/fqd_step.sv
// One restoring-division stage: shift, trial subtract, register.
module fqd_step
   import fqd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  fqd_stage_type stage_in,
   output fqd_stage_type stage_ff
);

   fqd_stage_type     stage_in_next;
   logic              carry;
   logic [DATA_W-1:0] shifted;
   logic [DATA_W:0]   diff;

   always_comb begin
      carry   = stage_in.rem[DATA_W-1];
      shifted = {stage_in.rem[DATA_W-2:0], stage_in.dvd[DATA_W-1]};
      diff    = {1'b0, shifted} - {1'b0, stage_in.den};

      stage_in_next     = stage_in;
      stage_in_next.dvd = {stage_in.dvd[DATA_W-2:0], 1'b0};
      // take the subtraction when the shifted-out bit or no borrow says it fits
      if (carry || !diff[DATA_W]) begin
         stage_in_next.rem = diff[DATA_W-1:0];
         stage_in_next.quo = {stage_in.quo[DATA_W-2:0], 1'b1};
      end else begin
         stage_in_next.rem = shifted;
         stage_in_next.quo = {stage_in.quo[DATA_W-2:0], 1'b0};
      end
   end

   // valid bit is reset; the data fields only load while the pipe advances
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_next.valid;
      end
      if (advance) begin
         stage_ff.not_a_number <= stage_in_next.not_a_number;
         stage_ff.rem          <= stage_in_next.rem;
         stage_ff.den          <= stage_in_next.den;
         stage_ff.dvd          <= stage_in_next.dvd;
         stage_ff.quo          <= stage_in_next.quo;
      end
   end

endmodule

>>> sv/fqd_out_buf.sv
// Two-word output buffer between the pipeline and the result channel.
module fqd_out_buf
   import fqd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fqd_rsp_type push_data,
   input  logic        out_stall,
   output logic        out_valid,
   output fqd_rsp_type out_data,
   output logic        full
);

   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic        pop;
   fqd_rsp_type slot_ff [2];

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/fraction_quotient_divider.sv
// Fraction quotient divider top level: restoring-division pipeline and output buffer.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  fqd_req_type {numerator, denominator}
//   rsp      out        rsp_valid/rsp_stall  fqd_rsp_type {fraction, not_a_number}
//
// One word enters per cycle while req_stall is low; each word passes through
// 128 restoring stages, one per quotient bit of {numerator, 64'b0} / denominator,
// and then through the output buffer.
// Reset (synchronous) clears the stage valid bits and empties the buffer.
// The whole pipeline holds while the two-word output buffer is full; req_stall
// follows that full flag, so a single word waiting on rsp does not block input.
`include "fraction_quotient_divider_defines.svh"

module fraction_quotient_divider
   import fqd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fqd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fqd_rsp_type rsp_data
);

   // Dividing {numerator, 64 zeros} by the denominator: the low 64 quotient
   // bits are exactly the fraction of numerator / denominator, so the
   // reduction modulo the denominator falls out of the first 64 steps.

   logic          advance;
   logic          buf_full;
   fqd_stage_type head;
   fqd_stage_type stage_d [STEPS];
   fqd_stage_type stage_q [STEPS];
   fqd_stage_type last;
   fqd_rsp_type   result;

   // advance every stage together; hold all when the buffer cannot take more
   assign advance   = !buf_full;
   assign req_stall = buf_full;

   always_comb begin
      head.valid        = req_valid;
      head.not_a_number = (req_data.denominator == '0);
      head.rem          = '0;
      head.den          = req_data.denominator;
      head.dvd          = req_data.numerator;
      head.quo          = '0;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign stage_d[i] = head;
      end else begin : g_rest
         assign stage_d[i] = stage_q[i-1];
      end
      fqd_step u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_in (stage_d[i]),
         .stage_ff (stage_q[i])
      );
   end

   assign last = stage_q[STEPS-1];

   // zero denominator: drop the quotient, raise the flag
   always_comb begin
      result.not_a_number = last.not_a_number;
      result.fraction     = last.not_a_number ? '0 : last.quo;
   end

   fqd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && last.valid),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (buf_full)
   );

   `FQD_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, stage_q[0].valid, "accepted word did not enter the first stage")
   `FQD_ASSERT_NEXT(a_last_reaches_out, clock, reset, advance && last.valid, rsp_valid, "finished word did not reach the output buffer")
   `FQD_ASSERT_NOW(a_nan_zero, clock, reset, rsp_valid && rsp_data.not_a_number, rsp_data.fraction == '0, "not-a-number result carries a non-zero fraction")

endmodule
